@@ hw/rtl/crm_pkg.sv @@
// Shared constants and types for the consecutive run merger.
package crm_pkg;

   // Field widths of the request and response channels.
   localparam int VALUE_W   = 10;
   localparam int LONGEST_W = 11;

   // Default size of the value window, in address bits.
   localparam int VALUE_BITS_DEF = 10;

   // Width of the set generation tag stored with every entry.
   localparam int EPOCH_BITS = 6;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_WR_LO,
      ST_WR_HI,
      ST_SWEEP
   } crm_state_type;

endpackage

@@ hw/rtl/crm_req_if.sv @@
// Request channel: one value to add to the set, with its restart flag.
interface crm_req_if;
   import crm_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               restart;

   modport source (output valid, output value, output restart, input ready);
   modport sink (input valid, input value, input restart, output ready);
endinterface

@@ hw/rtl/crm_rsp_if.sv @@
// Response channel: longest run length so far and the repeated flag.
interface crm_rsp_if;
   import crm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [LONGEST_W-1:0] longest;
   logic                 repeated;

   modport source (output valid, output longest, output repeated, input ready);
   modport sink (input valid, input longest, input repeated, output ready);
endinterface

@@ hw/rtl/crm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module crm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/consecutive_run_merger_top.sv @@
// Consecutive run merger: streams values into a set and reports the longest run of
// consecutive values after every transfer. Each value runs through steps set by the
// single write port of the entry memory: read the value and its lower neighbor, read
// the upper neighbor and mark the value, then, unless the value is repeated, write
// the two outer endpoints of the merged run. A one-entry request buffer and a
// response register let a transfer in and out while an item is in work, so the next
// value can be taken before the current one is done; an untaken result stalls it.
// Each memory entry holds a generation tag and the opposite run endpoint; a restart
// advances the tag. After reset, and on every 63rd restart when the tag wraps,
// a pass clears all 2^VALUE_BITS entries; no request is taken and the restart waits.
module consecutive_run_merger_top #(
   parameter int VALUE_BITS = crm_pkg::VALUE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   crm_req_if.sink    req,
   crm_rsp_if.source  rsp
);
   import crm_pkg::*;

   localparam int LEN_W = VALUE_BITS + 1;
   localparam int MEM_W = EPOCH_BITS + VALUE_BITS;
   localparam int DEPTH = 2 ** VALUE_BITS;
   localparam logic [VALUE_BITS-1:0] V_MAX = '1;

   // Request buffer.
   logic                  buf_valid_ff;
   logic [VALUE_BITS-1:0] buf_value_ff;
   logic                  buf_restart_ff;

   // Item in work and set state.
   crm_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0] v_ff;
   logic [VALUE_BITS-1:0] lo_ff;
   logic [VALUE_BITS-1:0] hi_ff;
   logic [EPOCH_BITS-1:0] epoch_ff;
   logic [LEN_W-1:0]      longest_ff;
   logic                  pend_ff;
   logic [VALUE_BITS-1:0] sweep_cnt_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic [LONGEST_W-1:0]  rsp_longest_ff;
   logic                  rsp_repeated_ff;

   // Combinational control.
   logic                  take;
   logic                  wrap;
   logic                  out_free;
   logic                  sweep_done;
   logic [VALUE_BITS-1:0] cur_v;
   logic                  present_v;
   logic [VALUE_BITS-1:0] lo_next;
   logic [VALUE_BITS-1:0] hi_next;
   logic [LEN_W-1:0]      run_len;
   logic [LEN_W-1:0]      longest_max;
   logic                  finish;
   logic                  finish_rep;

   // Memory ports.
   logic                  rd_a_en, rd_b_en, wr_en;
   logic [VALUE_BITS-1:0] rd_a_addr, rd_b_addr, wr_addr;
   logic [MEM_W-1:0]      wr_data, rd_a_data, rd_b_data;

   // Two copies with the same writes give two read ports.
   crm_ram #(.WIDTH(MEM_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_a_en),
      .rd_addr (rd_a_addr),
      .rd_data (rd_a_data)
   );

   crm_ram #(.WIDTH(MEM_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_b_en),
      .rd_addr (rd_b_addr),
      .rd_data (rd_b_data)
   );

   // Handshake and dispatch decisions.
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign take       = (state_ff == ST_IDLE) && buf_valid_ff;
   assign wrap       = buf_restart_ff && (epoch_ff == '1);
   assign sweep_done = (state_ff == ST_SWEEP) && (sweep_cnt_ff == V_MAX);
   assign cur_v      = (state_ff == ST_IDLE) ? buf_value_ff : v_ff;
   assign req.ready  = (!buf_valid_ff || take) && (state_ff != ST_SWEEP);

   // An entry belongs to the current set when its tag matches.
   assign present_v = rd_a_data[MEM_W-1 -: EPOCH_BITS] == epoch_ff;

   // Lower end of the merged run, from the lower neighbor's entry.
   always_comb begin
      if ((v_ff != '0) && (rd_b_data[MEM_W-1 -: EPOCH_BITS] == epoch_ff)) begin
         lo_next = rd_b_data[VALUE_BITS-1:0];
      end else begin
         lo_next = v_ff;
      end
   end

   // Upper end of the merged run, from the upper neighbor's entry.
   always_comb begin
      if ((v_ff != V_MAX) && (rd_a_data[MEM_W-1 -: EPOCH_BITS] == epoch_ff)) begin
         hi_next = rd_a_data[VALUE_BITS-1:0];
      end else begin
         hi_next = v_ff;
      end
   end

   // Length of the merged run and the new maximum.
   assign run_len     = {1'b0, hi_ff} - {1'b0, lo_ff} + LEN_W'(1);
   assign longest_max = (run_len > longest_ff) ? run_len : longest_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = wrap ? ST_SWEEP : ST_RD1;
            end
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            if (!present_v) begin
               state_in = ST_WR_LO;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WR_LO: begin
            state_in = ST_WR_HI;
         end
         ST_WR_HI: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = pend_ff ? ST_RD0 : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory accesses and completion strobes for each state.
   always_comb begin
      rd_a_en    = 1'b0;
      rd_a_addr  = cur_v;
      rd_b_en    = 1'b0;
      rd_b_addr  = cur_v - VALUE_BITS'(1);
      wr_en      = 1'b0;
      wr_addr    = v_ff;
      wr_data    = {epoch_ff, v_ff};
      finish     = 1'b0;
      finish_rep = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rd_a_en = take && !wrap;
            rd_b_en = take && !wrap;
         end
         ST_RD0: begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
         end
         ST_RD1: begin
            // Hold the value's entry while a repeated result waits for the output.
            rd_a_en    = !present_v || out_free;
            rd_a_addr  = v_ff + VALUE_BITS'(1);
            wr_en      = !present_v;
            finish_rep = present_v && out_free;
         end
         ST_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = {epoch_ff, hi_next};
         end
         ST_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = {epoch_ff, lo_ff};
            finish  = out_free;
         end
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_ff;
            wr_data = '0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Request buffer: a new transfer may land in the cycle the buffer drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         buf_valid_ff <= 1'b1;
      end else if (take) begin
         buf_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         buf_value_ff   <= VALUE_BITS'(req.value);
         buf_restart_ff <= req.restart;
      end
   end

   // Sequencer, generation tag, clearing pass and longest run.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         epoch_ff     <= '0;
         longest_ff   <= '0;
         pend_ff      <= 1'b0;
         sweep_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SWEEP) begin
            sweep_cnt_ff <= sweep_cnt_ff + VALUE_BITS'(1);
         end
         if (sweep_done) begin
            epoch_ff <= EPOCH_BITS'(1);
            pend_ff  <= 1'b0;
         end else if (take && buf_restart_ff) begin
            if (wrap) begin
               pend_ff <= 1'b1;
            end else begin
               epoch_ff <= epoch_ff + EPOCH_BITS'(1);
            end
         end
         if (take && buf_restart_ff) begin
            longest_ff <= '0;
         end else if (finish) begin
            longest_ff <= longest_max;
         end
      end
   end

   // Item registers: value, then the two endpoints as they are found.
   always_ff @(posedge clock) begin
      if (take) begin
         v_ff <= buf_value_ff;
      end
      if (state_ff == ST_RD1) begin
         lo_ff <= lo_next;
      end
      if (state_ff == ST_WR_LO) begin
         hi_ff <= hi_next;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish || finish_rep) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_longest_ff  <= LONGEST_W'(longest_max);
         rsp_repeated_ff <= 1'b0;
      end else if (finish_rep) begin
         rsp_longest_ff  <= LONGEST_W'(longest_ff);
         rsp_repeated_ff <= 1'b1;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.longest  = rsp_longest_ff;
   assign rsp.repeated = rsp_repeated_ff;

   // A completed merge always leaves a fresh, non-repeated result.
   a_merge_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_HI) && out_free |=> rsp_valid_ff && !rsp_repeated_ff)
      else $error("merge completed without a result");

   // Tag zero marks swept entries and is never the live generation.
   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SWEEP) |-> (epoch_ff != '0))
      else $error("live generation tag is zero");

   // The longest run only shrinks when a restart is dispatched.
   a_longest_mono: assert property (@(posedge clock) disable iff (reset)
      !(take && buf_restart_ff) |=> (longest_ff >= $past(longest_ff)))
      else $error("longest run decreased without a restart");

   // The merged run always brackets the new value.
   a_run_brackets: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_HI) |-> (lo_ff <= v_ff) && (v_ff <= hi_ff))
      else $error("run endpoints do not bracket the value");

endmodule
